[rtl/lcfr_pkg.sv]
// Shared types and codes for the length/checksum frame receiver.
`default_nettype none

package lcfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // event codes
    localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] EV_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] EV_ACCEPT  = 2'd2;
    localparam logic [KIND_W-1:0] EV_REJECT  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_MARKER = 2'd1;

    localparam logic [BYTE_W-1:0] FIRST_MARKER_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] SECOND_MARKER_RST = 8'd2;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_id;
    } lcfr_result_t;

endpackage

`default_nettype wire

[rtl/lcfr_deframer.sv]
// Deframing state machine with running checksum; one byte per step.
`default_nettype none

module lcfr_deframer
    import lcfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [BYTE_W-1:0] first_marker,
    input  wire logic [BYTE_W-1:0] second_marker,
    output lcfr_result_t           result
);

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_H = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_L = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ID    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SUM_H = 3'd5;
    localparam logic [PHASE_W-1:0] PH_SUM_L = 3'd6;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               armed_reg, armed_next;
    logic [WORD_W-1:0]  length_reg, length_next;
    logic [WORD_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  sum_hi_reg, sum_hi_next;
    logic [BYTE_W-1:0]  id_reg, id_next;
    logic [WORD_W-1:0]  got_sum;

    assign got_sum = {sum_hi_reg, rx_byte};

    always_comb begin
        phase_next  = phase_reg;
        armed_next  = armed_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        sum_hi_next = sum_hi_reg;
        id_next     = id_reg;
        result      = '{EV_NONE, '0, '0, '0};

        if (rx_byte == first_marker) begin
            armed_next = 1'b1;
        end else if (rx_byte == second_marker) begin
            if (armed_reg) begin
                armed_next = 1'b0;
                phase_next = PH_LEN_H;
                count_next = '0;
            end
        end else begin
            case (phase_reg)
                PH_LEN_H: begin
                    sum_next    = '0;
                    length_next = {rx_byte, {BYTE_W{1'b0}}};
                    phase_next  = PH_LEN_L;
                end
                PH_LEN_L: begin
                    length_next = {length_reg[WORD_W-1:BYTE_W], rx_byte};
                    phase_next  = PH_ID;
                end
                PH_ID: begin
                    id_next    = rx_byte;
                    sum_next   = {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
                    count_next = '0;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    result     = '{EV_PAYLOAD, rx_byte, count_reg, id_reg};
                    sum_next   = sum_reg + {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
                    count_next = count_reg + WORD_W'(1);
                    if (count_reg >= length_reg) begin
                        phase_next = PH_SUM_H;
                    end
                end
                PH_SUM_H: begin
                    sum_hi_next = rx_byte;
                    phase_next  = PH_SUM_L;
                end
                PH_SUM_L: begin
                    phase_next = PH_IDLE;
                    if (got_sum == sum_reg) begin
                        result = '{EV_ACCEPT, '0, '0, id_reg};
                    end else begin
                        result  = '{EV_REJECT, '0, '0, id_reg};
                        id_next = '0;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            armed_reg  <= 1'b0;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            sum_hi_reg <= '0;
            id_reg     <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            armed_reg  <= armed_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            sum_hi_reg <= sum_hi_next;
            id_reg     <= id_next;
        end
    end

endmodule

`default_nettype wire

[rtl/length_checksum_frame_receiver.sv]
// Top level of the length-prefixed frame receiver with additive checksum.
`default_nettype none

//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_rx_byte
//  m_        out        m_valid / m_ready  m_event_kind, m_payload_byte,
//                                          m_payload_index, m_frame_id
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
//  Every item gives exactly one result item, event 0 included.
//  Path: input register, then the deframer feeds the result register.
//  One item per cycle sustained while m_ready stays high; the path is one byte compare plus a 16-bit add.
//  A stalled m_ready holds the result register; the input register still takes
//  an item while it is empty, so ready drops only when both stages are full.
//  Synchronous active-low reset clears the frame state and loads marker defaults.

module length_checksum_frame_receiver
    import lcfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // byte input
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_rx_byte,
    // result output
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [KIND_W-1:0]         m_event_kind,
    output logic [BYTE_W-1:0]         m_payload_byte,
    output logic [WORD_W-1:0]         m_payload_index,
    output logic [BYTE_W-1:0]         m_frame_id,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wdata
);

    // marker registers
    logic [BYTE_W-1:0] first_marker_reg;
    logic [BYTE_W-1:0] second_marker_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_marker_reg  <= FIRST_MARKER_RST;
            second_marker_reg <= SECOND_MARKER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIRST_MARKER:  first_marker_reg  <= cfg_wdata;
                REG_SECOND_MARKER: second_marker_reg <= cfg_wdata;
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_free;
    logic              advance;
    lcfr_result_t      step_result;

    // result register is free when empty or being drained this cycle
    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // frame state machine; state moves only when its result is captured
    lcfr_deframer u_deframer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .first_marker  (first_marker_reg),
        .second_marker (second_marker_reg),
        .result        (step_result)
    );

    // result register
    logic         m_valid_reg;
    lcfr_result_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= step_result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = m_data_reg.event_kind;
    assign m_payload_byte  = m_data_reg.payload_byte;
    assign m_payload_index = m_data_reg.payload_index;
    assign m_frame_id      = m_data_reg.frame_id;

endmodule

`default_nettype wire

[tb/sv/lcfr_event_check.sv]
// Predicts the result item for every accepted byte and compares it with the block's output.
module lcfr_event_check
    import lcfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [BYTE_W-1:0]    s_rx_byte,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [KIND_W-1:0]    m_event_kind,
    input  wire logic [BYTE_W-1:0]    m_payload_byte,
    input  wire logic [WORD_W-1:0]    m_payload_index,
    input  wire logic [BYTE_W-1:0]    m_frame_id,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,
    output int                        mismatches,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_ID     = 3'd3,
        PH_DATA   = 3'd4,
        PH_SUM_HI = 3'd5,
        PH_SUM_LO = 3'd6
    } deframe_phase_t;

    // own copy of the marker registers and the deframer state
    logic [BYTE_W-1:0] mark_a, mark_b;
    deframe_phase_t    ph;
    logic              armed;
    logic [WORD_W-1:0] len_q, cnt_q, sum_q;
    logic [BYTE_W-1:0] sum_hi, id_q;

    lcfr_result_t predicted_events[$];
    int           bad = 0;

    function automatic lcfr_result_t deframe_byte(input logic [BYTE_W-1:0] b);
        lcfr_result_t      r;
        logic [WORD_W-1:0] got;
        r = '0;
        if (b == mark_a) begin
            armed = 1'b1;   // first marker wins when both registers match
        end else if (b == mark_b) begin
            if (armed) begin
                armed = 1'b0;
                ph    = PH_LEN_HI;
                cnt_q = '0;
            end
        end else begin
            case (ph)
                PH_LEN_HI: begin
                    sum_q = '0;
                    len_q = {b, 8'h00};
                    ph    = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_q = len_q | WORD_W'(b);
                    ph    = PH_ID;
                end
                PH_ID: begin
                    id_q  = b;
                    sum_q = WORD_W'(b);
                    cnt_q = '0;
                    ph    = PH_DATA;
                end
                PH_DATA: begin
                    r.event_kind    = EV_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = cnt_q;
                    r.frame_id      = id_q;
                    sum_q = sum_q + WORD_W'(b);
                    if (cnt_q >= len_q) begin
                        ph = PH_SUM_HI;
                    end
                    cnt_q = cnt_q + WORD_W'(1);
                end
                PH_SUM_HI: begin
                    sum_hi = b;
                    ph     = PH_SUM_LO;
                end
                PH_SUM_LO: begin
                    got        = {sum_hi, b};
                    ph         = PH_IDLE;
                    r.frame_id = id_q;
                    if (got == sum_q) begin
                        r.event_kind = EV_ACCEPT;
                    end else begin
                        r.event_kind = EV_REJECT;
                        id_q = '0;
                    end
                end
                default: begin
                    ph = PH_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        lcfr_result_t want, seen;
        if (!aresetn) begin
            mark_a = FIRST_MARKER_RST;
            mark_b = SECOND_MARKER_RST;
            ph     = PH_IDLE;
            armed  = 1'b0;
            len_q  = '0;
            cnt_q  = '0;
            sum_q  = '0;
            sum_hi = '0;
            id_q   = '0;
            predicted_events.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FIRST_MARKER:  mark_a = cfg_wdata;
                    REG_SECOND_MARKER: mark_b = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted_events.push_back(deframe_byte(s_rx_byte));
            end
            if (m_valid && m_ready) begin
                seen.event_kind    = m_event_kind;
                seen.payload_byte  = m_payload_byte;
                seen.payload_index = m_payload_index;
                seen.frame_id      = m_frame_id;
                if (predicted_events.size() == 0) begin
                    bad++;
                    if (bad <= 10) begin
                        $display({"%0t: result with none predicted: ",
                                  "kind %0d byte %02h idx %0d id %02h"},
                                 $realtime, seen.event_kind, seen.payload_byte,
                                 seen.payload_index, seen.frame_id);
                    end
                end else begin
                    want = predicted_events.pop_front();
                    if (seen.event_kind != want.event_kind ||
                        seen.payload_byte != want.payload_byte ||
                        seen.payload_index != want.payload_index ||
                        seen.frame_id != want.frame_id) begin
                        bad++;
                        if (bad <= 10) begin
                            $display("%0t: exp kind %0d byte %02h idx %0d id %02h", $realtime,
                                     want.event_kind, want.payload_byte,
                                     want.payload_index, want.frame_id);
                            $display("%0t: got kind %0d byte %02h idx %0d id %02h", $realtime,
                                     seen.event_kind, seen.payload_byte,
                                     seen.payload_index, seen.frame_id);
                        end
                    end
                end
            end
        end
        mismatches  <= bad;
        outstanding <= predicted_events.size();
    end

endmodule

[tb/sv/length_checksum_frame_receiver_tb.sv]
// Stimulus and verdict for the length/checksum frame receiver, with its event checker alongside.
module length_checksum_frame_receiver_tb;
    import lcfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the two marker registers; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [KIND_W-1:0]    m_event_kind;
    logic [BYTE_W-1:0]    m_payload_byte;
    logic [WORD_W-1:0]    m_payload_index;
    logic [BYTE_W-1:0]    m_frame_id;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;

    int          mismatches, outstanding;
    int unsigned cycles     = 0;
    int unsigned items_sent = 0;
    bit          quiet      = 1'b0;  // set for the closing stretch: no idling on either side
    bit          tx_calm    = 1'b0;  // sender stretch without gaps

    // markers as last written, so that frame content can steer clear of them
    logic [BYTE_W-1:0] mark_a = FIRST_MARKER_RST;
    logic [BYTE_W-1:0] mark_b = SECOND_MARKER_RST;

    length_checksum_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_id      (m_frame_id),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    lcfr_event_check frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_id      (m_frame_id),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("length_checksum_frame_receiver_tb: errors");
            $finish;
        end
    end

    // result side back-pressure: stretches that stall in bursts, others that never stall
    initial begin : result_stalls
        bit calm;
        forever begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(50, 300)) begin
                @(posedge aclk);
                if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // nudges a byte off both marker values so it stays data
    function automatic logic [BYTE_W-1:0] non_marker(input logic [BYTE_W-1:0] v);
        while (v == mark_a || v == mark_b) begin
            v = v + 8'd1;
        end
        return v;
    endfunction

    // one byte item; an optional gap first, then valid held until the handshake
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet && !tx_calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (items_sent % 100 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
    endtask

    // Builds a frame: markers, length, id, len+1 payload bytes, checksum.
    // corrupt spoils the checksum; keep, if non-zero, truncates the frame to that many bytes.
    task automatic send_frame(input logic [WORD_W-1:0] len, input bit corrupt,
                              input int unsigned keep);
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] hi, lo, tag, d;
        logic [WORD_W-1:0] n, sum;
        hi  = non_marker(len[15:8]);
        lo  = non_marker(len[7:0]);
        tag = non_marker(8'($urandom_range(0, 255)));
        n   = {hi, lo};
        sum = WORD_W'(tag);
        body = '{mark_a, mark_b, hi, lo, tag};
        // stop building early on a truncated frame so huge lengths stay cheap
        for (int i = 0; i <= int'(n) && (keep == 0 || body.size() < keep); i++) begin
            d   = non_marker(8'($urandom_range(0, 255)));
            sum = sum + WORD_W'(d);
            body.push_back(d);
        end
        if (corrupt) begin
            sum = sum ^ WORD_W'($urandom_range(1, 65535));
        end
        body.push_back(sum[15:8]);
        body.push_back(sum[7:0]);
        if (keep != 0 && keep < body.size()) begin
            body = body[0:keep-1];
        end
        foreach (body[i]) send_byte(body[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_FIRST_MARKER) begin
            mark_a = val;
        end else if (idx == REG_SECOND_MARKER) begin
            mark_b = val;
        end
    endtask

    task automatic load_markers(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        write_reg(REG_FIRST_MARKER, a);
        write_reg(REG_SECOND_MARKER, b);
        cfg_wr_en <= 1'b0;
    endtask

    // random distinct markers kept clear of small length bytes
    task automatic load_random_markers();
        logic [BYTE_W-1:0] a, b;
        a = 8'($urandom_range(8, 255));
        b = 8'($urandom_range(8, 255));
        if (a == b) begin
            b = a ^ 8'h01;
        end
        load_markers(a, b);
    endtask

    // hold the sender off until every predicted result has come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed frames with random content and lengths, some with a bad
    // checksum; the rest truncated frames, loose bytes and stray marker runs.
    task automatic random_traffic(input int unsigned stop_at);
        int unsigned       pick;
        logic [WORD_W-1:0] len;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                len = WORD_W'($urandom_range(8, 60));
            end else begin
                len = WORD_W'($urandom_range(0, 7));
            end
            if (pick < 65) begin
                send_frame(len, $urandom_range(0, 3) == 0, 0);
            end else if (pick < 78) begin
                send_frame(len, 1'b0, $urandom_range(1, 6 + int'(len)));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte($urandom_range(0, 1) ? mark_a : mark_b);
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // idle bytes and a second marker that was never armed: all ignored
        send_byte(8'hFF);
        send_byte(mark_b);

        // zero length carries one payload byte; sum 0x00FF matches -> accept
        send_byte(mark_a);
        send_byte(mark_b);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'hFF);

        // same shape, checksum wrong -> reject
        send_byte(mark_a);
        send_byte(mark_b);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'h00);

        // frame dropped mid-payload: first marker arms without counting as data,
        // a plain byte still streams, then the second marker restarts silently
        send_byte(mark_a);
        send_byte(mark_b);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(mark_a);
        send_byte(8'h11);
        send_byte(mark_b);

        // default markers; pause the sender partway until everything has drained
        random_traffic(400);
        settle();
        random_traffic(800);
        settle();

        // writes to the unused indexes, then fresh markers
        write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
        write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
        load_random_markers();
        send_frame(16'hFFFF, 1'b0, 12);  // full-size length, abandoned early
        random_traffic(1300);
        settle();

        // extreme markers: length bytes get pushed past zero, so payloads run past 256
        load_markers(8'h00, 8'hFF);
        send_frame(16'h0000, 1'b0, 0);
        send_frame(16'h0000, 1'b1, 0);
        settle();
        load_markers(8'hFF, 8'h00);
        send_frame(16'h0100, 1'b0, 0);
        send_frame(16'h0000, 1'b0, 40);
        repeat (8) send_byte(8'($urandom_range(0, 255)));
        settle();

        // equal markers: every marker byte only arms, so no frame can ever start
        begin : equal_markers
            logic [BYTE_W-1:0] m;
            m = 8'($urandom_range(0, 255));
            load_markers(m, m);
        end
        random_traffic(items_sent + 60);
        settle();

        // closing stretch at full rate on both sides
        load_random_markers();
        quiet = 1'b1;
        random_traffic(2050);
        settle();

        if (mismatches == 0) begin
            $display("length_checksum_frame_receiver_tb: clean");
        end else begin
            $display("length_checksum_frame_receiver_tb: errors");
        end
        $finish;
    end

endmodule
